/* design/isc_pkg.sv */
// Package for the interval set coalescer.
// Table geometry, entry layout, opcodes, result kinds and sequencer types.
// No dependencies.
package isc_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int OccW       = $clog2(TableDepth + 1);
  localparam int DataW      = 32;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_LIST     = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_ADD_DONE = 3'd0,
    KIND_ADD_FULL = 3'd1,
    KIND_CONTAINS = 3'd2,
    KIND_RANGE    = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_WRD,
    ST_WWR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] cnt;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic            en;
    logic            bank;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } mem_wr_t;

  typedef struct packed {
    logic            busy;
    logic [OccW-1:0] occ;
  } status_t;

endpackage

/* design/isc_if.sv */
// Request and result channel interfaces of the interval set coalescer.
// Valid/ready handshake; no package dependency.
interface isc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [31:0] range_count;

  modport source (output valid, opcode, range_start, range_end, range_count, input ready);
  modport sink   (input valid, opcode, range_start, range_end, range_count, output ready);
endinterface

interface isc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        hit;
  logic [31:0] out_start;
  logic [31:0] out_end;
  logic [31:0] out_count;
  logic        saturated;
  logic        last;

  modport source (output valid, kind, hit, out_start, out_end, out_count, saturated, last,
                  input ready);
  modport sink   (input valid, kind, hit, out_start, out_end, out_count, saturated, last,
                  output ready);
endinterface

/* design/isc_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
module isc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/isc_seq.sv */
// Sequencer and datapath: walks the table bank, merges, queries, coalesces,
// and copies the table into the other bank on add. Uses isc_pkg, isc_if.
module isc_seq (
  input  logic                   clk,
  input  logic                   rst,
  isc_in_if.sink                 request,
  isc_out_if.source              result,
  input  logic [31:0]            max_cnt,
  input  logic [31:0]            max_dist,
  input  isc_pkg::entry_t        rdata0,
  input  isc_pkg::entry_t        rdata1,
  output logic [isc_pkg::IdxW-1:0] rd_addr,
  output isc_pkg::mem_wr_t       wr,
  output isc_pkg::status_t       status
);

  isc_pkg::state_t  state, state_next;
  isc_pkg::opcode_t op;
  logic [isc_pkg::OccW-1:0] idx, occ, nfront, nmerge, kept, src;
  logic             bank, sat, hit, drop;
  logic [31:0]      ms, me, acc, pt, cs, ce, cc;
  isc_pkg::entry_t  ent;
  logic             at_end, is_before, is_after, join_ok, emit_mid, out_free, stall;
  logic [32:0]      acc_sum, lsum;
  logic [31:0]      gap;

  assign ent       = bank ? rdata1 : rdata0;
  assign at_end    = (idx == occ);
  assign is_before = (ent.hi < ms);
  assign is_after  = (ent.lo > me);
  assign acc_sum   = {1'b0, acc} + {1'b0, ent.cnt};
  assign kept      = occ - nmerge;
  assign gap       = ent.lo - ce;
  assign lsum      = {1'b0, cc} + {1'b0, ent.cnt};
  assign join_ok   = (idx != '0) && (gap <= max_dist) && (lsum <= {1'b0, max_cnt});
  assign emit_mid  = (op == isc_pkg::OP_LIST) && (idx != '0) && !join_ok;
  assign out_free  = !result.valid || result.ready;
  assign stall     = emit_mid && !out_free;
  // copy pass: entries ahead of the merged slot keep their place, later ones follow right after it
  assign src       = (idx < nfront) ? idx : (idx - isc_pkg::OccW'(1) + nmerge);

  assign request.ready = (state == isc_pkg::ST_IDLE);
  assign rd_addr = (state == isc_pkg::ST_WRD || state == isc_pkg::ST_WWR) ?
                   src[isc_pkg::IdxW-1:0] : idx[isc_pkg::IdxW-1:0];

  always_comb begin
    wr.en   = (state == isc_pkg::ST_WWR);
    wr.bank = ~bank;
    wr.addr = idx[isc_pkg::IdxW-1:0];
    wr.data = (idx == nfront) ? isc_pkg::entry_t'{lo: ms, hi: me, cnt: acc} : ent;
  end

  assign status.busy = (state != isc_pkg::ST_IDLE);
  assign status.occ  = occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      isc_pkg::ST_IDLE: begin
        if (request.valid && isc_pkg::opcode_t'(request.opcode) != isc_pkg::OP_NONE) begin
          state_next = isc_pkg::ST_RD;
        end
      end
      isc_pkg::ST_RD: begin
        if (!at_end) begin
          state_next = isc_pkg::ST_EV;
        end else if (op == isc_pkg::OP_ADD && kept != isc_pkg::OccW'(isc_pkg::TableDepth)) begin
          state_next = isc_pkg::ST_WRD;
        end else begin
          state_next = isc_pkg::ST_FIN;
        end
      end
      isc_pkg::ST_EV:  state_next = stall ? isc_pkg::ST_EV : isc_pkg::ST_RD;
      isc_pkg::ST_WRD: state_next = isc_pkg::ST_WWR;
      isc_pkg::ST_WWR: state_next = (idx == kept) ? isc_pkg::ST_FIN : isc_pkg::ST_WRD;
      isc_pkg::ST_FIN: state_next = out_free ? isc_pkg::ST_IDLE : isc_pkg::ST_FIN;
      default:         state_next = isc_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      bank <= 1'b0;
    end else if (state == isc_pkg::ST_WWR && idx == kept) begin
      bank <= ~bank;
      occ  <= kept + isc_pkg::OccW'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      isc_pkg::ST_IDLE: begin
        op     <= isc_pkg::opcode_t'(request.opcode);
        ms     <= (request.range_start < request.range_end) ? request.range_start
                                                             : request.range_end;
        me     <= (request.range_start < request.range_end) ? request.range_end
                                                             : request.range_start;
        acc    <= request.range_count;
        pt     <= request.range_start;
        sat    <= 1'b0;
        hit    <= 1'b0;
        drop   <= 1'b0;
        idx    <= '0;
        nfront <= '0;
        nmerge <= '0;
      end
      isc_pkg::ST_RD: begin
        if (at_end) begin
          drop <= (kept == isc_pkg::OccW'(isc_pkg::TableDepth));
          if (op == isc_pkg::OP_ADD) begin
            idx <= '0;
          end
        end
      end
      isc_pkg::ST_EV: begin
        if (!stall) begin
          idx <= idx + isc_pkg::OccW'(1);
          unique case (op)
            isc_pkg::OP_ADD: begin
              if (is_before) begin
                nfront <= nfront + isc_pkg::OccW'(1);
              end else if (!is_after) begin
                if (ent.lo < ms) ms <= ent.lo;
                if (ent.hi > me) me <= ent.hi;
                acc    <= acc_sum[32] ? '1 : acc_sum[31:0];
                sat    <= sat | acc_sum[32];
                nmerge <= nmerge + isc_pkg::OccW'(1);
              end
            end
            isc_pkg::OP_CONTAINS: begin
              if (ent.lo <= pt && pt <= ent.hi) hit <= 1'b1;
            end
            isc_pkg::OP_LIST: begin
              if (join_ok) begin
                ce <= ent.hi;
                cc <= lsum[31:0];
              end else begin
                cs <= ent.lo;
                ce <= ent.hi;
                cc <= ent.cnt;
              end
            end
            default: ;
          endcase
        end
      end
      isc_pkg::ST_WWR: idx <= idx + isc_pkg::OccW'(1);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free && (state == isc_pkg::ST_FIN ||
                              (state == isc_pkg::ST_EV && emit_mid))) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == isc_pkg::ST_EV && emit_mid) begin
      result.kind      <= isc_pkg::KIND_RANGE;
      result.hit       <= 1'b0;
      result.out_start <= cs;
      result.out_end   <= ce;
      result.out_count <= cc;
      result.saturated <= 1'b0;
      result.last      <= 1'b0;
    end else if (out_free && state == isc_pkg::ST_FIN) begin
      result.hit       <= 1'b0;
      result.out_start <= '0;
      result.out_end   <= '0;
      result.out_count <= '0;
      result.saturated <= 1'b0;
      result.last      <= 1'b1;
      unique case (op)
        isc_pkg::OP_ADD: begin
          result.kind      <= drop ? isc_pkg::KIND_ADD_FULL : isc_pkg::KIND_ADD_DONE;
          result.saturated <= !drop && sat;
        end
        isc_pkg::OP_CONTAINS: begin
          result.kind <= isc_pkg::KIND_CONTAINS;
          result.hit  <= hit;
        end
        default: begin
          if (occ == '0) begin
            result.kind <= isc_pkg::KIND_EMPTY;
          end else begin
            result.kind      <= isc_pkg::KIND_RANGE;
            result.out_start <= cs;
            result.out_end   <= ce;
            result.out_count <= cc;
          end
        end
      endcase
    end
  end

endmodule

/* design/interval_set_coalescer.sv */
// Interval set coalescer top: add, contains and list over a sorted range table.
// Contains and list scan every stored entry; add scans them and then, unless the table
// is full, copies the table into the other bank. One request at a time, the next taken
// the cycle after the final result is loaded; each entry passes a read state and an
// evaluate state (registered RAM read), and a list can stall there on the output.
// Reset (synchronous, active high): table empty, bank 0, limits max count / zero gap.
module interval_set_coalescer (
  input  logic        clk,
  input  logic        rst,
  isc_in_if.sink      request,
  isc_out_if.source   result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration limits
  logic [31:0] max_cnt, max_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cnt  <= '1;
      max_dist <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        max_cnt <= cfg_data;
      end else begin
        max_dist <= cfg_data;
      end
    end
  end

  // two table banks: the live one is read, an add that fits rebuilds into the other and flips
  isc_pkg::entry_t           rdata0, rdata1;
  logic [isc_pkg::IdxW-1:0]  rd_addr;
  isc_pkg::mem_wr_t          wr;
  isc_pkg::status_t          status;

  isc_ram #(.Width(isc_pkg::EntryW), .Depth(isc_pkg::TableDepth)) u_bank0 (
    .clk   (clk),
    .we    (wr.en && !wr.bank),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  isc_ram #(.Width(isc_pkg::EntryW), .Depth(isc_pkg::TableDepth)) u_bank1 (
    .clk   (clk),
    .we    (wr.en && wr.bank),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  isc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .result   (result),
    .max_cnt  (max_cnt),
    .max_dist (max_dist),
    .rdata0   (rdata0),
    .rdata1   (rdata1),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .status   (status)
  );

  // table never holds more than its depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    status.occ <= isc_pkg::OccW'(isc_pkg::TableDepth))
    else $error("occupancy beyond table depth");

  // while idle, any waiting result must be the final one of its request
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (!status.busy && result.valid) |-> result.last)
    else $error("non-final result pending while idle");

  // hit only on contains answers
  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.hit) |-> (result.kind == isc_pkg::KIND_CONTAINS))
    else $error("hit set on non-contains result");

  // range fields are zero except on range items
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != isc_pkg::KIND_RANGE) |->
      (result.out_start == '0 && result.out_end == '0 && result.out_count == '0))
    else $error("range fields set on non-range result");

  // no table writes while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !status.busy |-> !wr.en)
    else $error("table write while idle");

endmodule
